/* rtl/core/spb_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package spb_pkg;

   localparam int BANDS         = 32;
   localparam int BINS_PER_BAND = 8;

   localparam int BAND_AW  = (BANDS > 1) ? $clog2(BANDS) : 1;
   localparam int BAND_CW  = $clog2(BANDS + 1);
   localparam int BIN_CW   = (BINS_PER_BAND > 1) ? $clog2(BINS_PER_BAND) : 1;

   localparam int MAG_W     = 16;
   localparam int SUM_W     = 24;
   localparam int WEIGHT_W  = 19;
   localparam int DH_W      = 10;
   localparam int CFG4_W    = 4;
   localparam int FLOOR_W   = 11;
   localparam int FALL_W    = 8;
   localparam int HOLD_W    = 5;
   localparam int BAND_OUT_W = 8;
   localparam int PROD_W    = SUM_W + WEIGHT_W;
   localparam int X_W       = PROD_W + FLOOR_W;
   localparam int XFRAC_W   = 32;
   localparam int XI_W      = X_W - XFRAC_W;
   localparam int ROW_W     = 25;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = DH_W;

   localparam logic [CSR_IDX_W-1:0] CSR_DISPLAY_HEIGHT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HOLD_FRAMES    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PEAK_FALL_ROWS = 2'd2;

   localparam logic [DH_W-1:0]   DH_RESET  = 10'd100;
   localparam logic [CFG4_W-1:0] HF_RESET  = 4'd5;
   localparam logic [CFG4_W-1:0] PFR_RESET = 4'd3;

   localparam logic [63:0] WEIGHT_K = 64'd54511;

   typedef struct packed {
      logic [FLOOR_W-1:0] bar;
      logic [FALL_W-1:0]  fall;
      logic [FLOOR_W-1:0] peak;
      logic [HOLD_W-1:0]  hold;   // two's complement, -1..15
   } spb_rec_type;

   localparam int REC_W = $bits(spb_rec_type);

   localparam spb_rec_type REC_RESET = '{
      bar:  11'd100,
      fall: 8'd1,
      peak: 11'd100,
      hold: 5'd5
   };

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_W,
      ST_MUL_F,
      ST_TARGET,
      ST_BAR,
      ST_PEAK,
      ST_OUT
   } spb_state_type;

   typedef struct packed {
      logic req_accept;
      logic load_rec;
      logic mul_floor;
      logic calc_target;
      logic calc_bar;
      logic calc_peak;
   } spb_cmd_type;

   typedef struct packed {
      logic band_done;
      logic bin_last;
   } spb_stat_type;

   // 1.2*ln(n) in Q3.16 via log2 by repeated squaring; elaboration only
   function automatic logic [WEIGHT_W-1:0] band_weight(input int unsigned n);
      int unsigned ip;
      int unsigned t;
      logic [63:0] m;
      logic [63:0] frac;
      logic [63:0] lg;
      logic [63:0] w;
      int i;
      ip = 0;
      t = n;
      frac = '0;
      for (i = 0; i < 32; i++) begin
         if (t > 1) begin
            t = t >> 1;
            ip = ip + 1;
         end
      end
      m = (64'(n) << 30) >> ip;
      for (i = 0; i < 16; i++) begin
         m = (m * m) >> 30;
         frac = frac << 1;
         if (m >= 64'h8000_0000) begin
            m = m >> 1;
            frac = frac | 64'd1;
         end
      end
      lg = (64'(ip) << 16) | frac;
      w = (lg * WEIGHT_K + 64'd32768) >> 16;
      return w[WEIGHT_W-1:0];
   endfunction

endpackage

`default_nettype wire

/* rtl/core/spb_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module spb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  wire logic                                        clock,
   input  wire logic                                        wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                            wr_data,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* rtl/core/spb_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none

module spb_datapath (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire spb_pkg::spb_cmd_type                cmd,
   output spb_pkg::spb_stat_type                    stat,
   input  wire logic [spb_pkg::MAG_W-1:0]           req_bin_magnitude,
   input  wire logic                                req_frame_start,
   input  wire logic                                csr_we,
   input  wire logic [spb_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [spb_pkg::CSR_DATA_W-1:0]      csr_wdata,
   output logic      [spb_pkg::BAND_OUT_W-1:0]      rsp_band_index,
   output logic      [spb_pkg::FLOOR_W-1:0]         rsp_bar_top_row,
   output logic      [spb_pkg::FLOOR_W-1:0]         rsp_peak_row,
   output logic                                     rsp_last_band
);

   // configuration
   logic [spb_pkg::DH_W-1:0]   dh_ff,  dh_in;
   logic [spb_pkg::CFG4_W-1:0] hf_ff,  hf_in;
   logic [spb_pkg::CFG4_W-1:0] pfr_ff, pfr_in;

   // accumulator
   logic [spb_pkg::BIN_CW-1:0]  bin_cnt_ff,  bin_cnt_in;
   logic [spb_pkg::BAND_CW-1:0] band_cnt_ff, band_cnt_in;
   logic [spb_pkg::SUM_W-1:0]   sum_ff,      sum_in;
   logic [spb_pkg::BIN_CW-1:0]  bin_base;
   logic [spb_pkg::BAND_CW-1:0] band_base;
   logic [spb_pkg::SUM_W-1:0]   sum_base;
   logic [spb_pkg::SUM_W-1:0]   sum_add;
   logic                        band_active;
   logic                        bin_at_end;
   logic                        band_done;

   // band job
   logic [spb_pkg::BAND_AW-1:0] job_band_ff, job_band_in;
   logic [spb_pkg::SUM_W-1:0]   job_sum_ff,  job_sum_in;
   spb_pkg::spb_rec_type        rec_ff,      rec_in;
   logic [spb_pkg::PROD_W-1:0]  prod_ff,     prod_in;
   logic [spb_pkg::X_W-1:0]     x_ff,        x_in;
   logic signed [spb_pkg::ROW_W-1:0] target_ff, target_in;
   logic signed [spb_pkg::ROW_W-1:0] top_ff,    top_in;
   logic [spb_pkg::FALL_W-1:0]  fs_ff,       fs_in;
   logic [spb_pkg::BANDS-1:0]   valid_ff,    valid_in;

   // result word
   logic [spb_pkg::BAND_OUT_W-1:0] out_band_ff, out_band_in;
   logic [spb_pkg::FLOOR_W-1:0]    out_bar_ff,  out_bar_in;
   logic [spb_pkg::FLOOR_W-1:0]    out_peak_ff, out_peak_in;
   logic                           out_last_ff, out_last_in;

   logic [spb_pkg::WEIGHT_W-1:0] weight_tab [spb_pkg::BANDS];
   logic [spb_pkg::FLOOR_W-1:0]  floor_row;
   logic [spb_pkg::XI_W-1:0]     xi;
   logic                         xfrac;
   logic [spb_pkg::XI_W:0]       x_sub;
   logic signed [spb_pkg::ROW_W-1:0] floor_s;
   logic signed [spb_pkg::ROW_W-1:0] bar_old_s;
   logic signed [spb_pkg::ROW_W-1:0] bar_sum_s;
   logic signed [spb_pkg::ROW_W-1:0] peak_old_s;
   logic signed [spb_pkg::ROW_W-1:0] peak_s;
   logic signed [spb_pkg::ROW_W-1:0] top_clamp_s;
   logic [spb_pkg::FALL_W-1:0]   fs_inc;
   logic [spb_pkg::HOLD_W-1:0]   hold_new;
   spb_pkg::spb_rec_type         rec_wr;
   spb_pkg::spb_rec_type         ram_rd;

   for (genvar g = 0; g < spb_pkg::BANDS; g++) begin : g_weight
      assign weight_tab[g] = spb_pkg::band_weight(32'(g + 2));
   end

   assign floor_row = spb_pkg::FLOOR_W'(dh_ff) + spb_pkg::FLOOR_W'(2);
   assign floor_s   = signed'(spb_pkg::ROW_W'(floor_row));

   // configuration writes
   always_comb begin
      dh_in  = dh_ff;
      hf_in  = hf_ff;
      pfr_in = pfr_ff;
      if (csr_we) begin
         unique case (csr_index)
            spb_pkg::CSR_DISPLAY_HEIGHT: dh_in  = csr_wdata;
            spb_pkg::CSR_HOLD_FRAMES:    hf_in  = csr_wdata[spb_pkg::CFG4_W-1:0];
            spb_pkg::CSR_PEAK_FALL_ROWS: pfr_in = csr_wdata[spb_pkg::CFG4_W-1:0];
            default: ;
         endcase
      end
   end

   // bin accumulation
   always_comb begin
      bin_base    = req_frame_start ? '0 : bin_cnt_ff;
      band_base   = req_frame_start ? '0 : band_cnt_ff;
      sum_base    = req_frame_start ? '0 : sum_ff;
      band_active = band_base < spb_pkg::BAND_CW'(spb_pkg::BANDS);
      sum_add     = sum_base + spb_pkg::SUM_W'(req_bin_magnitude);
      bin_at_end  = bin_base == spb_pkg::BIN_CW'(spb_pkg::BINS_PER_BAND - 1);
      band_done   = cmd.req_accept && band_active && bin_at_end;

      bin_cnt_in  = bin_cnt_ff;
      band_cnt_in = band_cnt_ff;
      sum_in      = sum_ff;
      job_band_in = job_band_ff;
      job_sum_in  = job_sum_ff;
      if (cmd.req_accept) begin
         bin_cnt_in  = bin_base;
         band_cnt_in = band_base;
         sum_in      = sum_base;
         if (band_active) begin
            if (bin_at_end) begin
               bin_cnt_in  = '0;
               sum_in      = '0;
               band_cnt_in = band_base + spb_pkg::BAND_CW'(1);
               job_band_in = band_base[spb_pkg::BAND_AW-1:0];
               job_sum_in  = sum_add;
            end else begin
               bin_cnt_in = bin_base + spb_pkg::BIN_CW'(1);
               sum_in     = sum_add;
            end
         end
      end
   end

   assign stat.band_done = band_done;
   assign stat.bin_last  = bin_cnt_ff == spb_pkg::BIN_CW'(spb_pkg::BINS_PER_BAND - 1);

   // per-band math
   always_comb begin
      rec_in  = valid_ff[job_band_ff] ? ram_rd : spb_pkg::REC_RESET;
      prod_in = spb_pkg::PROD_W'(job_sum_ff) * spb_pkg::PROD_W'(weight_tab[job_band_ff]);
      x_in    = spb_pkg::X_W'(prod_ff) * spb_pkg::X_W'(floor_row);

      // target row: floor minus scaled level, truncated toward zero
      xi        = x_ff[spb_pkg::X_W-1:spb_pkg::XFRAC_W];
      xfrac     = |x_ff[spb_pkg::XFRAC_W-1:0];
      x_sub     = (xi >= spb_pkg::XI_W'(floor_row)) ? {1'b0, xi}
                : {1'b0, xi} + (spb_pkg::XI_W + 1)'(xfrac);
      target_in = floor_s - signed'(spb_pkg::ROW_W'(x_sub));

      // bar: jump up at once, else fall with growing step
      bar_old_s = signed'(spb_pkg::ROW_W'(rec_ff.bar));
      fs_inc    = (rec_ff.fall == '1) ? rec_ff.fall : rec_ff.fall + spb_pkg::FALL_W'(1);
      bar_sum_s = bar_old_s + signed'(spb_pkg::ROW_W'(fs_inc));
      if (target_ff < bar_old_s) begin
         top_in = target_ff;
         fs_in  = spb_pkg::FALL_W'(2);
      end else begin
         top_in = (bar_sum_s > floor_s) ? floor_s : bar_sum_s;
         fs_in  = fs_inc;
      end

      // peak marker
      peak_old_s = signed'(spb_pkg::ROW_W'(rec_ff.peak));
      if (top_ff < peak_old_s) begin
         peak_s   = (top_ff > signed'(spb_pkg::ROW_W'(0)))
                  ? top_ff - signed'(spb_pkg::ROW_W'(1)) : '0;
         hold_new = spb_pkg::HOLD_W'(hf_ff);
      end else begin
         hold_new = (rec_ff.hold == '1) ? rec_ff.hold
                  : rec_ff.hold - spb_pkg::HOLD_W'(1);
         peak_s   = hold_new[spb_pkg::HOLD_W-1]
                  ? peak_old_s + signed'(spb_pkg::ROW_W'(pfr_ff)) : peak_old_s;
         if (peak_s > floor_s) begin
            peak_s = floor_s;
         end
      end

      priority if (top_ff < signed'(spb_pkg::ROW_W'(0))) begin
         top_clamp_s = '0;
      end else if (top_ff > floor_s) begin
         top_clamp_s = floor_s;
      end else begin
         top_clamp_s = top_ff;
      end

      rec_wr.bar  = top_clamp_s[spb_pkg::FLOOR_W-1:0];
      rec_wr.fall = fs_ff;
      rec_wr.peak = peak_s[spb_pkg::FLOOR_W-1:0];
      rec_wr.hold = hold_new;

      valid_in = valid_ff;
      if (cmd.calc_peak) begin
         valid_in[job_band_ff] = 1'b1;
      end

      out_band_in = spb_pkg::BAND_OUT_W'(job_band_ff);
      out_bar_in  = rec_wr.bar;
      out_peak_in = rec_wr.peak;
      out_last_in = job_band_ff == spb_pkg::BAND_AW'(spb_pkg::BANDS - 1);
   end

   spb_ram #(
      .WIDTH (spb_pkg::REC_W),
      .DEPTH (spb_pkg::BANDS)
   ) u_band_ram (
      .clock   (clock),
      .wr_en   (cmd.calc_peak),
      .wr_addr (job_band_ff),
      .wr_data (rec_wr),
      .rd_addr (band_base[spb_pkg::BAND_AW-1:0]),
      .rd_data (ram_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         dh_ff       <= spb_pkg::DH_RESET;
         hf_ff       <= spb_pkg::HF_RESET;
         pfr_ff      <= spb_pkg::PFR_RESET;
         bin_cnt_ff  <= '0;
         band_cnt_ff <= '0;
         sum_ff      <= '0;
         valid_ff    <= '0;
      end else begin
         dh_ff       <= dh_in;
         hf_ff       <= hf_in;
         pfr_ff      <= pfr_in;
         bin_cnt_ff  <= bin_cnt_in;
         band_cnt_ff <= band_cnt_in;
         sum_ff      <= sum_in;
         valid_ff    <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_band_ff <= job_band_in;
      job_sum_ff  <= job_sum_in;
      if (cmd.load_rec) begin
         rec_ff  <= rec_in;
         prod_ff <= prod_in;
      end
      if (cmd.mul_floor) begin
         x_ff <= x_in;
      end
      if (cmd.calc_target) begin
         target_ff <= target_in;
      end
      if (cmd.calc_bar) begin
         top_ff <= top_in;
         fs_ff  <= fs_in;
      end
      if (cmd.calc_peak) begin
         out_band_ff <= out_band_in;
         out_bar_ff  <= out_bar_in;
         out_peak_ff <= out_peak_in;
         out_last_ff <= out_last_in;
      end
   end

   assign rsp_band_index  = out_band_ff;
   assign rsp_bar_top_row = out_bar_ff;
   assign rsp_peak_row    = out_peak_ff;
   assign rsp_last_band   = out_last_ff;

endmodule

`default_nettype wire

/* rtl/core/spb_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module spb_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   input  wire spb_pkg::spb_stat_type stat,
   output spb_pkg::spb_cmd_type       cmd
);

   spb_pkg::spb_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= spb_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      // a band-closing word waits until the previous band is delivered
      req_ready = (state_ff == spb_pkg::ST_IDLE) || !stat.bin_last;
      rsp_valid = 1'b0;
      cmd       = '0;
      cmd.req_accept = req_valid && req_ready;
      unique case (state_ff)
         spb_pkg::ST_IDLE: begin
            if (stat.band_done) begin
               state_in = spb_pkg::ST_MUL_W;
            end
         end
         spb_pkg::ST_MUL_W: begin
            cmd.load_rec = 1'b1;
            state_in     = spb_pkg::ST_MUL_F;
         end
         spb_pkg::ST_MUL_F: begin
            cmd.mul_floor = 1'b1;
            state_in      = spb_pkg::ST_TARGET;
         end
         spb_pkg::ST_TARGET: begin
            cmd.calc_target = 1'b1;
            state_in        = spb_pkg::ST_BAR;
         end
         spb_pkg::ST_BAR: begin
            cmd.calc_bar = 1'b1;
            state_in     = spb_pkg::ST_PEAK;
         end
         spb_pkg::ST_PEAK: begin
            cmd.calc_peak = 1'b1;
            state_in      = spb_pkg::ST_OUT;
         end
         spb_pkg::ST_OUT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               state_in = spb_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = spb_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

/* rtl/core/spectrum_bar_peak_hold.sv */
// Spectrum analyzer bars with falloff and peak hold.
// req channel: one FFT bin magnitude word per handshake; req_frame_start
// marks the first bin of a frame. Every 8 bins close one band, 32 bands
// make a frame; bins past the last band are dropped until the next frame.
// rsp channel: one word per closed band with band index, bar top row,
// peak marker row and a last-band flag.
// The result word is worked out in states MUL_W, MUL_F, TARGET, BAR and
// PEAK of a shared multiply/update sequence and is offered in OUT. Bins
// are taken one per cycle, but a band's last bin is held off until the
// previous band's word has been taken, so at 8 bins per band the input
// runs at one word a cycle while rsp_ready stays high.
// A stalled receiver holds the result word; bin words keep being taken
// until the next band is about to close.
// Reset clears the counters, loads the register defaults (height 100,
// hold 5, fall 3) and marks every band's state as fresh (bar and peak at
// row 100, fall step 1, hold count 5). csr writes act at once.
`timescale 1ns / 1ps
`default_nettype none

module spectrum_bar_peak_hold (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic [spb_pkg::MAG_W-1:0]           req_bin_magnitude,
   input  wire logic                                req_frame_start,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic      [spb_pkg::BAND_OUT_W-1:0]      rsp_band_index,
   output logic      [spb_pkg::FLOOR_W-1:0]         rsp_bar_top_row,
   output logic      [spb_pkg::FLOOR_W-1:0]         rsp_peak_row,
   output logic                                     rsp_last_band,
   input  wire logic                                csr_we,
   input  wire logic [spb_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [spb_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   spb_pkg::spb_cmd_type  cmd;
   spb_pkg::spb_stat_type stat;

   spb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   spb_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_bin_magnitude (req_bin_magnitude),
      .req_frame_start   (req_frame_start),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .rsp_band_index    (rsp_band_index),
      .rsp_bar_top_row   (rsp_bar_top_row),
      .rsp_peak_row      (rsp_peak_row),
      .rsp_last_band     (rsp_last_band)
   );

endmodule

`default_nettype wire
